// ----- rtl/core/fcb_pkg.sv -----
// Shared types and constants for the floppy read command builder.
package fcb_pkg;

  localparam int LBA_W  = 13;
  localparam int BYTE_W = 8;
  localparam int SECT_W = 6;
  localparam int STAT_W = 3;
  localparam int IDX_W  = 4;

  localparam int QUEUE_DEPTH = 2;

  // input item kinds
  localparam logic KIND_READ   = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // output item kinds
  localparam logic OUT_CMD    = 1'b0;
  localparam logic OUT_STATUS = 1'b1;

  // read-data command bytes
  localparam logic [BYTE_W-1:0] READ_OPCODE = 8'hC6;
  localparam logic [BYTE_W-1:0] SIZE_CODE   = 8'h02;
  localparam logic [BYTE_W-1:0] GAP_LENGTH  = 8'h1B;
  localparam logic [BYTE_W-1:0] DATA_LENGTH = 8'hFF;

  // position of each byte in the command run
  localparam logic [IDX_W-1:0] BYTE_OPCODE = 4'd0;
  localparam logic [IDX_W-1:0] BYTE_HDS    = 4'd1;
  localparam logic [IDX_W-1:0] BYTE_CYL    = 4'd2;
  localparam logic [IDX_W-1:0] BYTE_HEAD   = 4'd3;
  localparam logic [IDX_W-1:0] BYTE_SECT   = 4'd4;
  localparam logic [IDX_W-1:0] BYTE_SIZE   = 4'd5;
  localparam logic [IDX_W-1:0] BYTE_EOT    = 4'd6;
  localparam logic [IDX_W-1:0] BYTE_GAP    = 4'd7;
  localparam logic [IDX_W-1:0] BYTE_DTL    = 4'd8;

  // result phase
  localparam logic [2:0] RESULT_BYTES = 3'd7;
  localparam logic [2:0] CNT_ST0      = 3'd0;
  localparam logic [2:0] CNT_ST1      = 3'd1;
  localparam logic [2:0] CNT_FINAL    = 3'd6;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_END_CYL   = 3'd1;
  localparam logic [STAT_W-1:0] ST_CRC       = 3'd2;
  localparam logic [STAT_W-1:0] ST_OVERRUN   = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_DATA   = 3'd4;
  localparam logic [STAT_W-1:0] ST_WPROT     = 3'd5;
  localparam logic [STAT_W-1:0] ST_NO_MARK   = 3'd6;
  localparam logic [STAT_W-1:0] ST_UNKNOWN   = 3'd7;

  // one queued job for the back end
  typedef struct packed {
    logic              is_status;
    logic [BYTE_W-1:0] cyl;
    logic              head;
    logic [SECT_W-1:0] sector;
    logic [STAT_W-1:0] code;
  } fcb_job_t;

endpackage

// ----- rtl/core/floppy_read_command_builder_unit.sv -----
// Floppy read-data command builder top level.
//
// Input channel (in_valid/in_stall): a read request (in_kind 0) carries an
// LBA; a result byte (in_kind 1) carries one controller result-phase byte.
// Output channel (out_valid/out_stall): a read request yields nine command
// bytes (out_kind 0, out_last on the ninth); the seventh result byte after a
// request yields one status item (out_kind 1). Further result bytes are dropped.
// cfg_we/cfg_drive_select writes the drive number placed in command byte one.
//
// An item passes front-end stages s1 and s2, the job queue and the output
// register. Throughput: with out_stall low the output register sends one item
// per cycle, so a read request holds the output for nine bytes; result bytes are
// taken one per cycle while in_stall is low. A two-entry job queue sits between
// the CHS front end and the byte sequencer, so new items are taken while command
// bytes still go out; in_stall rises only when that queue is full. An output stall
// holds the current item. Reset (synchronous, rst_n low) clears the drive number,
// the result count, the saved ST0/ST1, the queue and all valid flags.
module floppy_read_command_builder_unit import fcb_pkg::*; #(
  parameter int SECTORS_PER_TRACK = 18,
  parameter int HEAD_COUNT        = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_drive_select,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [LBA_W-1:0]  in_lba,
  input  logic [BYTE_W-1:0] in_result_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [BYTE_W-1:0] out_byte_value,
  output logic [STAT_W-1:0] out_status_code,
  output logic              out_last
);

  logic     q_full;
  logic     push;
  fcb_job_t push_job;
  logic     pop;
  logic     head_valid;
  fcb_job_t head_job;

  fcb_front #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK),
    .HEAD_COUNT        (HEAD_COUNT)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_kind        (in_kind),
    .in_lba         (in_lba),
    .in_result_byte (in_result_byte),
    .q_full         (q_full),
    .push           (push),
    .push_job       (push_job)
  );

  fcb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  fcb_back #(
    .SECTORS_PER_TRACK (SECTORS_PER_TRACK)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_drive_select (cfg_drive_select),
    .head_valid       (head_valid),
    .head_job         (head_job),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_status_code  (out_status_code),
    .out_last         (out_last)
  );

endmodule

// ----- rtl/core/fcb_front.sv -----
// Front end: accepts items, splits the LBA into CHS, tracks the result phase.
module fcb_front import fcb_pkg::*; #(
  parameter int SECTORS_PER_TRACK = 18,
  parameter int HEAD_COUNT        = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_kind,
  input  logic [LBA_W-1:0]  in_lba,
  input  logic [BYTE_W-1:0] in_result_byte,
  input  logic              q_full,
  output logic              push,
  output fcb_job_t          push_job
);

  localparam int PerCyl     = SECTORS_PER_TRACK * HEAD_COUNT;
  localparam int RecipShift = 20;
  localparam int Recip      = (1 << RecipShift) / PerCyl;
  localparam int RECIP_W    = $clog2(Recip + 1);
  localparam int PROD_W     = LBA_W + RECIP_W;
  localparam int CYL_W      = $clog2(((1 << LBA_W) - 1) / PerCyl + 1);
  localparam int REM_W      = $clog2(PerCyl + 1);

  localparam logic [RECIP_W-1:0] RECIP_V   = RECIP_W'(Recip);
  localparam logic [LBA_W-1:0]   PER_CYL_V = LBA_W'(PerCyl);
  localparam logic [REM_W-1:0]   SPT_V     = REM_W'(SECTORS_PER_TRACK);

  logic adv;

  // stage 1: reciprocal product
  logic              s1_valid_r;
  logic              s1_kind_r;
  logic [LBA_W-1:0]  s1_lba_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic [PROD_W-1:0] s1_prod_r;

  // stage 2: cylinder and remainder
  logic              s2_valid_r;
  logic              s2_kind_r;
  logic [CYL_W-1:0]  s2_cyl_r;
  logic [REM_W-1:0]  s2_rem_r;
  logic [BYTE_W-1:0] s2_byte_r;

  // result phase state
  logic [2:0]        count_r;
  logic [BYTE_W-1:0] st0_r;
  logic [BYTE_W-1:0] st1_r;

  logic [PROD_W-1:0] prod;
  logic [CYL_W-1:0]  q_est;
  logic [LBA_W-1:0]  q_mul;
  logic [LBA_W-1:0]  diff;
  logic              fix;
  logic [CYL_W-1:0]  cyl;
  logic [REM_W-1:0]  rem;
  logic              head;
  logic [REM_W-1:0]  sect;
  logic              is_result;
  logic              take_byte;
  logic              final_byte;

  function automatic logic [STAT_W-1:0] decode_status(input logic [BYTE_W-1:0] st0,
                                                      input logic [BYTE_W-1:0] st1);
    logic [STAT_W-1:0] code;
    if ((st0 & 8'hC0) == 8'h00) code = ST_OK;
    else if (st1[7])            code = ST_END_CYL;
    else if (st1[5])            code = ST_CRC;
    else if (st1[4])            code = ST_OVERRUN;
    else if (st1[2])            code = ST_NO_DATA;
    else if (st1[1])            code = ST_WPROT;
    else if (st1[0])            code = ST_NO_MARK;
    else                        code = ST_UNKNOWN;
    return code;
  endfunction

  // whole pipeline moves together; it freezes only on a full queue
  assign adv      = !q_full;
  assign in_stall = q_full;

  assign prod = PROD_W'(in_lba) * PROD_W'(RECIP_V);

  // estimate is exact or one low; one compare-subtract corrects it
  assign q_est = CYL_W'(s1_prod_r[PROD_W-1:RecipShift]);
  assign q_mul = LBA_W'(q_est) * PER_CYL_V;
  assign diff  = s1_lba_r - q_mul;
  assign fix   = (diff >= PER_CYL_V);
  assign cyl   = fix ? q_est + CYL_W'(1) : q_est;
  assign rem   = fix ? REM_W'(diff - PER_CYL_V) : REM_W'(diff);

  assign head = (s2_rem_r >= SPT_V);
  assign sect = (head ? s2_rem_r - SPT_V : s2_rem_r) + REM_W'(1);

  assign is_result  = (s2_kind_r == KIND_RESULT);
  assign take_byte  = s2_valid_r && adv && is_result && (count_r < RESULT_BYTES);
  assign final_byte = take_byte && (count_r == CNT_FINAL);

  assign push = s2_valid_r && adv && (!is_result || final_byte);

  always_comb begin
    push_job           = '0;
    push_job.is_status = is_result;
    push_job.cyl       = BYTE_W'(s2_cyl_r);
    push_job.head      = head;
    push_job.sector    = SECT_W'(sect);
    push_job.code      = decode_status(st0_r, st1_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r <= in_kind;
      s1_lba_r  <= in_lba;
      s1_byte_r <= in_result_byte;
      s1_prod_r <= prod;
      s2_kind_r <= s1_kind_r;
      s2_cyl_r  <= cyl;
      s2_rem_r  <= rem;
      s2_byte_r <= s1_byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      st0_r   <= '0;
      st1_r   <= '0;
    end else if (s2_valid_r && adv && !is_result) begin
      count_r <= '0;
    end else if (take_byte) begin
      if (count_r == CNT_ST0) st0_r <= s2_byte_r;
      if (count_r == CNT_ST1) st1_r <= s2_byte_r;
      count_r <= count_r + 3'd1;
    end
  end

endmodule

// ----- rtl/core/fcb_queue.sv -----
// Short job queue between the front and back ends.
module fcb_queue import fcb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  fcb_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output fcb_job_t head_job
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  fcb_job_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

endmodule

// ----- rtl/core/fcb_back.sv -----
// Back end: plays out the nine command bytes or the status item per job.
module fcb_back import fcb_pkg::*; #(
  parameter int SECTORS_PER_TRACK = 18
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_drive_select,
  input  logic              head_valid,
  input  fcb_job_t          head_job,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_kind,
  output logic [BYTE_W-1:0] out_byte_value,
  output logic [STAT_W-1:0] out_status_code,
  output logic              out_last
);

  localparam logic [BYTE_W-1:0] EOT_V = BYTE_W'(SECTORS_PER_TRACK);

  logic [1:0]        drive_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic              out_kind_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_last_r;

  logic              load;
  logic              done;
  logic [BYTE_W-1:0] cmd_byte;

  assign load = head_valid && (!out_valid_r || !out_stall);
  assign done = head_job.is_status || (idx_r == BYTE_DTL);
  assign pop  = load && done;

  always_comb begin
    unique case (idx_r)
      BYTE_OPCODE: cmd_byte = READ_OPCODE;
      BYTE_HDS:    cmd_byte = {5'b0, head_job.head, drive_r};
      BYTE_CYL:    cmd_byte = head_job.cyl;
      BYTE_HEAD:   cmd_byte = {7'b0, head_job.head};
      BYTE_SECT:   cmd_byte = BYTE_W'(head_job.sector);
      BYTE_SIZE:   cmd_byte = SIZE_CODE;
      BYTE_EOT:    cmd_byte = EOT_V;
      BYTE_GAP:    cmd_byte = GAP_LENGTH;
      BYTE_DTL:    cmd_byte = DATA_LENGTH;
      default:     cmd_byte = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
    end else if (cfg_we) begin
      drive_r <= cfg_drive_select;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= BYTE_OPCODE;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r       <= done ? BYTE_OPCODE : idx_r + IDX_W'(1);
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (head_job.is_status) begin
        out_kind_r   <= OUT_STATUS;
        out_byte_r   <= '0;
        out_status_r <= head_job.code;
        out_last_r   <= 1'b0;
      end else begin
        out_kind_r   <= OUT_CMD;
        out_byte_r   <= cmd_byte;
        out_status_r <= ST_OK;
        out_last_r   <= (idx_r == BYTE_DTL);
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_byte_value  = out_byte_r;
  assign out_status_code = out_status_r;
  assign out_last        = out_last_r;

endmodule

// ----- tb/floppy_read_command_builder_unit_tb.sv -----
// Self-checking testbench for the floppy read command builder top level.
module floppy_read_command_builder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fcb_pkg::*;

  localparam int TRACK_SECTORS = 18;
  localparam int HEADS         = 2;
  localparam int ITEM_TARGET   = 370;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 70;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] value;
    logic [STAT_W-1:0] code;
    logic              last;
  } fdc_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_we = 1'b0;
  logic [1:0]        cfg_drive_select = 2'd0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_kind = KIND_READ;
  logic [LBA_W-1:0]  in_lba = '0;
  logic [BYTE_W-1:0] in_result_byte = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte_value;
  logic [STAT_W-1:0] out_status_code;
  logic              out_last;

  // predictor state
  logic [1:0]        drive_sel = 2'd0;
  logic [2:0]        phase_count = 3'd0;
  logic [BYTE_W-1:0] st0_kept = '0;
  logic [BYTE_W-1:0] st1_kept = '0;

  fdc_item_t   cmd_and_status_q[$];
  int unsigned counted_items = 0;
  int unsigned mismatches = 0;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  int unsigned hold_cycles = 0;

  floppy_read_command_builder_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_drive_select (cfg_drive_select),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_lba           (in_lba),
    .in_result_byte   (in_result_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_byte_value   (out_byte_value),
    .out_status_code  (out_status_code),
    .out_last         (out_last)
  );

  always #10 clk = ~clk;

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [STAT_W-1:0] decode_read_status(input logic [BYTE_W-1:0] st0,
                                                          input logic [BYTE_W-1:0] st1);
    if ((st0 & 8'hC0) == 8'h00) return ST_OK;
    if (st1[7]) return ST_END_CYL;
    if (st1[5]) return ST_CRC;
    if (st1[4]) return ST_OVERRUN;
    if (st1[2]) return ST_NO_DATA;
    if (st1[1]) return ST_WPROT;
    if (st1[0]) return ST_NO_MARK;
    return ST_UNKNOWN;
  endfunction

  function automatic void push_cmd_byte(input int unsigned value, input logic last);
    cmd_and_status_q.push_back('{OUT_CMD, BYTE_W'(value), ST_OK, last});
  endfunction

  // LBA -> CHS, then the nine bytes of the read-data command
  function automatic void predict_read_command(input logic [LBA_W-1:0] lba);
    int unsigned cyl, rem, head, sect;
    cyl  = lba / (TRACK_SECTORS * HEADS);
    rem  = lba % (TRACK_SECTORS * HEADS);
    head = rem / TRACK_SECTORS;
    sect = rem % TRACK_SECTORS + 1;
    push_cmd_byte(READ_OPCODE, 1'b0);
    push_cmd_byte((head << 2) | drive_sel, 1'b0);
    push_cmd_byte(cyl, 1'b0);
    push_cmd_byte(head, 1'b0);
    push_cmd_byte(sect, 1'b0);
    push_cmd_byte(SIZE_CODE, 1'b0);
    push_cmd_byte(TRACK_SECTORS, 1'b0);
    push_cmd_byte(GAP_LENGTH, 1'b0);
    push_cmd_byte(DATA_LENGTH, 1'b1);
    phase_count = 3'd0;
  endfunction

  // returns 0 when the byte is dropped past the end of the result phase
  function automatic bit predict_result_byte(input logic [BYTE_W-1:0] rb);
    if (phase_count >= RESULT_BYTES) return 1'b0;
    if (phase_count == 3'd0) st0_kept = rb;
    else if (phase_count == 3'd1) st1_kept = rb;
    phase_count = phase_count + 3'd1;
    if (phase_count == RESULT_BYTES)
      cmd_and_status_q.push_back('{OUT_STATUS, 8'h00, decode_read_status(st0_kept, st1_kept),
                                   1'b0});
    return 1'b1;
  endfunction

  // called at a rising edge; returns at the edge where the item is taken
  task automatic send_item(input logic kind, input logic [LBA_W-1:0] lba,
                           input logic [BYTE_W-1:0] rb);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_kind        <= kind;
    in_lba         <= lba;
    in_result_byte <= rb;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (kind == KIND_READ) begin
      predict_read_command(lba);
      counted_items++;
    end else if (predict_result_byte(rb)) begin
      counted_items++;
    end
  endtask

  task automatic send_read(input logic [LBA_W-1:0] lba);
    send_item(KIND_READ, lba, BYTE_W'($urandom));
  endtask

  task automatic send_result(input logic [BYTE_W-1:0] rb);
    send_item(KIND_RESULT, LBA_W'($urandom), rb);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (cmd_and_status_q.size() != 0) @(posedge clk);
    // result bytes that produce nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_drive(input logic [1:0] value);
    wait_idle();
    cfg_we           <= 1'b1;
    cfg_drive_select <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    drive_sel = value;
  endtask

  // result bytes straight out of reset count as a phase; the eighth is dropped
  task automatic test_orphan_results();
    send_result(8'h80);
    send_result(8'h01);
    repeat (5) send_result(8'h00);
    send_result(8'hAA);
  endtask

  task automatic test_lba_corners();
    send_read(13'd0);
    send_read(13'd17);
    send_read(13'd18);
    send_read(13'd36);
  endtask

  // end of cylinder wins when every ST1 error bit is set
  task automatic test_status_priority();
    send_read(13'd100);
    send_result(8'h40);
    send_result(8'hFF);
    repeat (5) send_result(8'h5A);
  endtask

  // a new request restarts the result phase at ST0
  task automatic test_phase_restart();
    send_read(13'd37);
    send_result(8'hC0);
    send_result(8'h00);
    send_read(13'd8191);
    send_result(8'h3F);
    send_result(8'hFF);
    repeat (5) send_result(8'hC0);
  endtask

  task automatic test_output_hold();
    set_drive(2'd3);
    tx_idle_on  = 1'b0;
    hold_cycles = HOLD_CYCLES;
    repeat (6) send_read(LBA_W'($urandom));
    tx_idle_on = 1'b1;
  endtask

  task automatic run_read_phase();
    int unsigned mode, n_bytes, k;
    logic [BYTE_W-1:0] st0, st1, rb;
    mode = $urandom_range(0, 19);
    if ($urandom_range(0, 1)) st0 = {2'($urandom_range(1, 3)), 6'($urandom)};
    else st0 = {2'b00, 6'($urandom)};
    case ($urandom_range(0, 9))
      0: st1 = 8'h80;
      1: st1 = 8'h20;
      2: st1 = 8'h10;
      3: st1 = 8'h04;
      4: st1 = 8'h02;
      5: st1 = 8'h01;
      6: st1 = 8'h00;
      7: st1 = {1'b0, 1'($urandom), 1'b0, 1'b0, 1'($urandom), 3'b000};
      default: st1 = BYTE_W'($urandom);
    endcase
    if (mode == 0) begin
      // stray result bytes with no new request
      n_bytes = $urandom_range(1, 3);
    end else begin
      send_read(LBA_W'($urandom));
      if (mode <= 2) n_bytes = $urandom_range(0, 6);
      else if (mode <= 4) n_bytes = $urandom_range(8, 10);
      else n_bytes = 7;
    end
    for (k = 0; k < n_bytes; k++) begin
      rb = (k == 0) ? st0 : (k == 1) ? st1 : BYTE_W'($urandom);
      send_result(rb);
    end
  endtask

  task automatic test_random_traffic();
    logic [1:0]  drives[4];
    int unsigned start_count, r;
    drives      = '{2'd3, 2'd0, 2'd2, 2'd1};
    start_count = counted_items;
    for (r = 0; r < 4; r++) begin
      set_drive(drives[r]);
      tx_idle_on = (r == 0) || (r == 2);
      rx_idle_on = (r == 0) || (r == 3);
      while (counted_items < start_count + (ITEM_TARGET - start_count) * (r + 1) / 4)
        run_read_phase();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_orphan_results();
    test_lba_corners();
    test_status_priority();
    test_phase_restart();
    test_output_hold();
    test_random_traffic();
    wait_idle();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side: random stall before each item, one long hold on request
  initial begin : result_sink
    int unsigned wait_cycles;
    forever begin
      wait_cycles = rx_idle_on ? $urandom_range(0, 8) : 0;
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
    end
  end

  always @(posedge clk) begin : result_check
    fdc_item_t got, want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_kind, out_byte_value, out_status_code, out_last};
      if (cmd_and_status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: kind=%0d byte=%02h code=%0d last=%0d",
                   got.kind, got.value, got.code, got.last);
      end else begin
        want = cmd_and_status_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: expected kind=%0d byte=%02h code=%0d last=%0d, got kind=%0d byte=%02h code=%0d last=%0d",
                     want.kind, want.value, want.code, want.last,
                     got.kind, got.value, got.code, got.last);
        end
      end
    end
  end

endmodule

// ----- floppy_read_command_builder_unit.f -----
rtl/core/fcb_pkg.sv
rtl/core/fcb_front.sv
rtl/core/fcb_queue.sv
rtl/core/fcb_back.sv
rtl/core/floppy_read_command_builder_unit.sv
tb/floppy_read_command_builder_unit_tb.sv
